### hdl/ttsu_pkg.sv
// Package with the slot record type, codes and sizes of the time-triggered task scheduler.
`default_nettype none
package ttsu_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    localparam logic [2:0] KIND_ADDED       = 3'd0;
    localparam logic [2:0] KIND_TABLE_FULL  = 3'd1;
    localparam logic [2:0] KIND_DELETED     = 3'd2;
    localparam logic [2:0] KIND_DEL_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_TICK_DONE   = 3'd4;
    localparam logic [2:0] KIND_RUN_TASK    = 3'd5;
    localparam logic [2:0] KIND_NO_DISPATCH = 3'd6;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY    = 2'd1;
    localparam logic [1:0] ERR_CANT_DELETE = 2'd2;

    localparam logic [3:0] FULL_SLOT = 4'(TASK_SLOTS % 16);

    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } slot_rec_t;

    function automatic logic [3:0] slot_code(input logic [IDX_W-1:0] v);
        logic [IDX_W+3:0] w;
        w = {4'b0000, v};
        return w[3:0];
    endfunction

endpackage
`default_nettype wire

### hdl/ttsu_cell.sv
// One slot cell of the scheduler ring, holding a task record and passing it on.
`default_nettype none
module ttsu_cell
    import ttsu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      shift_en,
    input  wire slot_rec_t rec_in,
    output slot_rec_t      rec_out
);

    slot_rec_t rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else if (shift_en)
        begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule
`default_nettype wire

### hdl/time_triggered_task_scheduler_unit.sv
// Top level of the time-triggered task scheduler: slot ring, head update and request control.
// Each request makes one full turn of the slot ring before its final result,
// and the ring moves one slot past the head update per cycle.
// A new request is accepted once busy falls, so a request enters only after the last one has finished.
// Dispatch run results appear during the turn, the last one at the end; results cannot be stalled.
// Reset clears all slots, the sticky error and the control state.
`default_nettype none
module time_triggered_task_scheduler_unit
    import ttsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  task_handle,
    input  wire logic [15:0] first_delay,
    input  wire logic [15:0] repeat_period,
    input  wire logic [2:0]  slot_index,
    output logic             result_valid,
    output logic [2:0]       kind,
    output logic [3:0]       slot,
    output logic [7:0]       run_handle,
    output logic             last,
    output logic [1:0]       error_code
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    slot_rec_t chain [TASK_SLOTS];
    slot_rec_t head_next;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       op_reg;
    logic [7:0]       handle_reg;
    logic [15:0]      delay_reg;
    logic [15:0]      period_reg;
    logic [2:0]       index_reg;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_slot_reg, found_slot_next;
    logic             del_empty_reg, del_empty_next;
    logic [1:0]       error_reg, error_next;
    logic [RES_W-1:0] nres_reg, nres_next;
    logic             buf_valid_reg, buf_valid_next;
    logic [IDX_W-1:0] buf_slot_reg, buf_slot_next;
    logic [7:0]       buf_handle_reg, buf_handle_next;

    logic             valid_next;
    logic [2:0]       kind_next;
    logic [3:0]       slot_next;
    logic [7:0]       run_handle_next;
    logic             last_next;
    logic [1:0]       error_code_next;

    logic             shift_en;
    logic             accept;
    logic             in_range;
    slot_rec_t        head;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign shift_en = (state_reg == ST_SCAN);
    assign head     = chain[0];
    assign in_range = (32'(index_reg) < TASK_SLOTS);

    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        slot_rec_t cell_in;
        if (i == TASK_SLOTS - 1)
        begin : g_tail
            assign cell_in = head_next;
        end
        else
        begin : g_mid
            assign cell_in = chain[i+1];
        end
        ttsu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .rec_in   (cell_in),
            .rec_out  (chain[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        del_empty_next  = del_empty_reg;
        error_next      = error_reg;
        nres_next       = nres_reg;
        buf_valid_next  = buf_valid_reg;
        buf_slot_next   = buf_slot_reg;
        buf_handle_next = buf_handle_reg;
        head_next       = head;
        valid_next      = 1'b0;
        kind_next       = kind;
        slot_next       = slot;
        run_handle_next = run_handle;
        last_next       = last;
        error_code_next = error_code;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next     = ST_SCAN;
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    del_empty_next = 1'b0;
                    nres_next      = '0;
                    buf_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (!found_reg && head.handle == 8'd0)
                        begin
                            head_next.handle  = handle_reg;
                            head_next.delay   = delay_reg;
                            head_next.period  = period_reg;
                            head_next.pending = 8'd0;
                            found_next        = 1'b1;
                            found_slot_next   = cnt_reg;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (32'(cnt_reg) == 32'(index_reg))
                        begin
                            del_empty_next = (head.handle == 8'd0);
                            head_next      = '0;
                        end
                    end
                    OP_TICK:
                    begin
                        if (head.handle != 8'd0)
                        begin
                            if (head.delay == 16'd0)
                            begin
                                if (head.pending != 8'd255)
                                begin
                                    head_next.pending = head.pending + 8'd1;
                                end
                                if (head.period != 16'd0)
                                begin
                                    head_next.delay = head.period;
                                end
                            end
                            else
                            begin
                                head_next.delay = head.delay - 16'd1;
                            end
                        end
                    end
                    OP_DISPATCH:
                    begin
                        if (head.pending != 8'd0 && nres_reg < RES_W'(MAX_RESULTS))
                        begin
                            head_next.pending = head.pending - 8'd1;
                            if (head.period == 16'd0)
                            begin
                                if (head.handle == 8'd0)
                                begin
                                    error_next = ERR_CANT_DELETE;
                                end
                                head_next = '0;
                            end
                            if (buf_valid_reg)
                            begin
                                valid_next      = 1'b1;
                                kind_next       = KIND_RUN_TASK;
                                slot_next       = slot_code(buf_slot_reg);
                                run_handle_next = buf_handle_reg;
                                last_next       = 1'b0;
                                error_code_next = error_reg;
                            end
                            buf_valid_next  = 1'b1;
                            buf_slot_next   = cnt_reg;
                            buf_handle_next = head.handle;
                            nres_next       = nres_reg + RES_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (cnt_reg == IDX_W'(TASK_SLOTS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                state_next      = ST_IDLE;
                valid_next      = 1'b1;
                last_next       = 1'b1;
                run_handle_next = 8'd0;
                slot_next       = 4'd0;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (found_reg)
                        begin
                            kind_next = KIND_ADDED;
                            slot_next = slot_code(found_slot_reg);
                        end
                        else
                        begin
                            kind_next  = KIND_TABLE_FULL;
                            slot_next  = FULL_SLOT;
                            error_next = ERR_TOO_MANY;
                        end
                    end
                    OP_DELETE:
                    begin
                        slot_next = {1'b0, index_reg};
                        if (!in_range || del_empty_reg)
                        begin
                            kind_next  = KIND_DEL_EMPTY;
                            error_next = ERR_CANT_DELETE;
                        end
                        else
                        begin
                            kind_next = KIND_DELETED;
                        end
                    end
                    OP_TICK:
                    begin
                        kind_next = KIND_TICK_DONE;
                    end
                    OP_DISPATCH:
                    begin
                        if (buf_valid_reg)
                        begin
                            kind_next       = KIND_RUN_TASK;
                            slot_next       = slot_code(buf_slot_reg);
                            run_handle_next = buf_handle_reg;
                        end
                        else
                        begin
                            kind_next = KIND_NO_DISPATCH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                error_code_next = error_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            del_empty_reg <= 1'b0;
            error_reg     <= ERR_NONE;
            nres_reg      <= '0;
            buf_valid_reg <= 1'b0;
            result_valid  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            del_empty_reg <= del_empty_next;
            error_reg     <= error_next;
            nres_reg      <= nres_next;
            buf_valid_reg <= buf_valid_next;
            result_valid  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            handle_reg <= task_handle;
            delay_reg  <= first_delay;
            period_reg <= repeat_period;
            index_reg  <= slot_index;
        end
        found_slot_reg <= found_slot_next;
        buf_slot_reg   <= buf_slot_next;
        buf_handle_reg <= buf_handle_next;
        kind           <= kind_next;
        slot           <= slot_next;
        run_handle     <= run_handle_next;
        last           <= last_next;
        error_code     <= error_code_next;
    end

endmodule
`default_nettype wire
